[design/tals_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_pkg
// Shared widths, codes and types of the turn, alarm and fall LED sequencer.
// ----------------------------------------------------------------------------
package tals_pkg;

  localparam int STATUS_W = 2;
  localparam int CMD_W    = 3;
  localparam int PAT_W    = 2;
  localparam int PHASE_W  = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [STATUS_W-1:0] ST_FALL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEFT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RIGHT = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT_ON   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT_ON  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT_OFF = 3'd4;

  localparam logic [PAT_W-1:0] PAT_DARK  = 2'd0;
  localparam logic [PAT_W-1:0] PAT_RED   = 2'd1;
  localparam logic [PAT_W-1:0] PAT_LEFT  = 2'd2;
  localparam logic [PAT_W-1:0] PAT_RIGHT = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TURN = 2'd1;
  localparam logic [1:0] MODE_PROX = 2'd2;
  localparam logic [1:0] MODE_FALL = 2'd3;

  localparam logic [1:0] PH_TOP = 2'd0;
  localparam logic [1:0] PH_ON  = 2'd1;
  localparam logic [1:0] PH_OFF = 2'd2;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  localparam logic [2:0] REG_BLINK_COUNT     = 3'd0;
  localparam logic [2:0] REG_BLINK_ON_TICKS  = 3'd1;
  localparam logic [2:0] REG_BLINK_OFF_TICKS = 3'd2;
  localparam logic [2:0] REG_FRAME_TICKS     = 3'd3;
  localparam logic [2:0] REG_TURN_TICKS      = 3'd4;

  localparam logic [3:0] BLINK_COUNT_RST     = 4'd5;
  localparam logic [7:0] BLINK_ON_TICKS_RST  = 8'd10;
  localparam logic [7:0] BLINK_OFF_TICKS_RST = 8'd10;
  localparam logic [7:0] FRAME_TICKS_RST     = 8'd12;
  localparam logic [9:0] TURN_TICKS_RST      = 10'd200;

  typedef struct packed {
    logic [3:0] blink_count;
    logic [7:0] blink_on_ticks;
    logic [7:0] blink_off_ticks;
    logic [7:0] frame_ticks;
    logic [9:0] turn_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] ride_status;
    logic                obstacle_near;
    logic [CMD_W-1:0]    spoken_command;
  } item_t;

  typedef struct packed {
    logic [PAT_W-1:0]   pattern;
    logic [PHASE_W-1:0] rainbow_phase;
    logic               refresh;
  } result_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         tick_count;
    logic [3:0]         blink_index;
    logic [1:0]         turn_side;
    logic               near_latched;
    logic [1:0]         held_voice_side;
    logic [7:0]         frame_step;
    logic [CMD_W-1:0]   pending_command;
    logic [7:0]         wait_left;
    logic [1:0]         phase;
    logic [PAT_W-1:0]   shown_pat;
    logic [PHASE_W-1:0] shown_phase;
  } state_t;

  localparam state_t STATE_RST = '0;

  // remaining hold ticks after a write; zero counts as one
  function automatic logic [7:0] hold_ticks(input logic [7:0] t);
    return (t == 8'd0) ? 8'd0 : t - 8'd1;
  endfunction

endpackage
`default_nettype wire

[design/tals_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_in_if
// Request channel: one tick of ride status, proximity alarm and command.
// ----------------------------------------------------------------------------
interface tals_in_if;
  logic                          valid;
  logic                          ready;
  logic [tals_pkg::STATUS_W-1:0] ride_status;
  logic                          obstacle_near;
  logic [tals_pkg::CMD_W-1:0]    spoken_command;

  modport source (output valid, ride_status, obstacle_near, spoken_command, input ready);
  modport sink   (input valid, ride_status, obstacle_near, spoken_command, output ready);
endinterface
`default_nettype wire

[design/tals_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_out_if
// Result channel: LED pattern, rainbow frame step and refresh flag.
// ----------------------------------------------------------------------------
interface tals_out_if;
  logic                         valid;
  logic                         ready;
  logic [tals_pkg::PAT_W-1:0]   pattern;
  logic [tals_pkg::PHASE_W-1:0] rainbow_phase;
  logic                         refresh;

  modport source (output valid, pattern, rainbow_phase, refresh, input ready);
  modport sink   (input valid, pattern, rainbow_phase, refresh, output ready);
endinterface
`default_nettype wire

[design/tals_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_cfg_regs
// APB register bank for blink, frame and turn timing.
// ----------------------------------------------------------------------------
module tals_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tals_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tals_pkg::DATA_W-1:0] pwdata,
  output logic      [tals_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output tals_pkg::cfg_t                   cfg
);
  import tals_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_count     <= BLINK_COUNT_RST;
      cfg_r.blink_on_ticks  <= BLINK_ON_TICKS_RST;
      cfg_r.blink_off_ticks <= BLINK_OFF_TICKS_RST;
      cfg_r.frame_ticks     <= FRAME_TICKS_RST;
      cfg_r.turn_ticks      <= TURN_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLINK_COUNT:     cfg_r.blink_count     <= pwdata[3:0];
        REG_BLINK_ON_TICKS:  cfg_r.blink_on_ticks  <= pwdata[7:0];
        REG_BLINK_OFF_TICKS: cfg_r.blink_off_ticks <= pwdata[7:0];
        REG_FRAME_TICKS:     cfg_r.frame_ticks     <= pwdata[7:0];
        REG_TURN_TICKS:      cfg_r.turn_ticks      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLINK_COUNT:     prdata = {28'd0, cfg_r.blink_count};
      REG_BLINK_ON_TICKS:  prdata = {24'd0, cfg_r.blink_on_ticks};
      REG_BLINK_OFF_TICKS: prdata = {24'd0, cfg_r.blink_off_ticks};
      REG_FRAME_TICKS:     prdata = {24'd0, cfg_r.frame_ticks};
      REG_TURN_TICKS:      prdata = {22'd0, cfg_r.turn_ticks};
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/tals_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_step
// One tick of the sequencer: next state and the strip write for that tick.
// ----------------------------------------------------------------------------
module tals_step (
  input  wire tals_pkg::cfg_t   cfg,
  input  wire tals_pkg::state_t cur_st,
  input  wire tals_pkg::item_t  item,
  output tals_pkg::state_t      st_nxt,
  output tals_pkg::result_t     res
);
  import tals_pkg::*;

  logic [3:0]       count_m;
  logic [7:0]       frame_m;
  logic [9:0]       turn_m;
  logic [CMD_W-1:0] pend;
  logic [10:0]      elapsed;
  logic [3:0]       bi_inc;
  logic             near;
  logic             go_top;
  logic             wrote;
  state_t           nx;

  assign count_m = (cfg.blink_count == 4'd0) ? 4'd1 : cfg.blink_count;
  assign frame_m = (cfg.frame_ticks == 8'd0) ? 8'd1 : cfg.frame_ticks;
  assign turn_m  = (cfg.turn_ticks == 10'd0) ? 10'd1 : cfg.turn_ticks;
  assign near    = item.obstacle_near;
  assign elapsed = {1'b0, cur_st.tick_count} + {3'd0, frame_m};
  assign bi_inc  = (cur_st.blink_index != 4'hF) ? cur_st.blink_index + 4'd1
                                                 : cur_st.blink_index;

  always_comb begin
    pend = cur_st.pending_command;
    if (item.spoken_command inside {[CMD_LEFT_ON:CMD_RIGHT_OFF]}) begin
      pend = item.spoken_command;
    end
    nx = cur_st;
    nx.pending_command = pend;
    wrote  = 1'b0;
    go_top = 1'b0;

    if (cur_st.wait_left != 8'd0) begin
      nx.wait_left = cur_st.wait_left - 8'd1;
    end else if (cur_st.mode == MODE_TURN) begin
      if (elapsed < {1'b0, turn_m} && pend == CMD_NONE) begin
        nx.tick_count  = elapsed[9:0];
        nx.shown_pat   = (cur_st.turn_side == SIDE_LEFT) ? PAT_LEFT : PAT_RIGHT;
        nx.shown_phase = nx.frame_step;
        nx.frame_step  = nx.frame_step + 8'd1;
        nx.wait_left   = hold_ticks(cfg.frame_ticks);
        wrote          = 1'b1;
      end else begin
        nx.mode       = MODE_IDLE;
        nx.tick_count = 10'd0;
        go_top        = 1'b1;
      end
    end else if ((cur_st.mode == MODE_PROX || cur_st.mode == MODE_FALL) &&
                 cur_st.phase != PH_TOP) begin
      if (cur_st.phase == PH_ON) begin
        nx.phase       = PH_OFF;
        nx.shown_pat   = PAT_DARK;
        nx.shown_phase = '0;
        nx.wait_left   = hold_ticks(cfg.blink_off_ticks);
        wrote          = 1'b1;
      end else begin
        nx.blink_index = bi_inc;
        if (bi_inc < count_m && (cur_st.mode == MODE_FALL || near)) begin
          nx.phase       = PH_ON;
          nx.shown_pat   = PAT_RED;
          nx.shown_phase = '0;
          nx.wait_left   = hold_ticks(cfg.blink_on_ticks);
          wrote          = 1'b1;
        end else begin
          go_top = 1'b1;
        end
      end
    end else begin
      go_top = 1'b1;
    end

    if (go_top) begin
      if (item.ride_status == ST_FALL) begin
        nx.mode        = MODE_FALL;
        nx.blink_index = 4'd0;
        nx.phase       = PH_ON;
        nx.shown_pat   = PAT_RED;
        nx.shown_phase = '0;
        nx.wait_left   = hold_ticks(cfg.blink_on_ticks);
        wrote          = 1'b1;
      end else begin
        if (pend != CMD_NONE) begin
          nx.pending_command = CMD_NONE;
          if (pend == CMD_LEFT_ON || pend == CMD_RIGHT_ON) begin
            nx.held_voice_side = (pend == CMD_LEFT_ON) ? SIDE_LEFT : SIDE_RIGHT;
            nx.frame_step      = nx.frame_step + 8'd1;
          end else begin
            nx.held_voice_side = SIDE_NONE;
          end
          nx.mode        = MODE_IDLE;
          nx.blink_index = 4'd0;
        end
        if (nx.mode == MODE_FALL) begin
          nx.phase     = PH_TOP;
          nx.wait_left = 8'd0;
        end else if (nx.mode == MODE_PROX && near) begin
          nx.blink_index = 4'd0;
          nx.phase       = PH_ON;
          nx.shown_pat   = PAT_RED;
          nx.shown_phase = '0;
          nx.wait_left   = hold_ticks(cfg.blink_on_ticks);
          wrote          = 1'b1;
        end else begin
          if (nx.mode == MODE_PROX) begin
            nx.near_latched = 1'b0;
          end
          nx.mode = MODE_IDLE;
          if (near && !nx.near_latched) begin
            nx.near_latched = 1'b1;
            nx.mode         = MODE_PROX;
            nx.blink_index  = 4'd0;
          end
          if (!near) begin
            nx.near_latched = 1'b0;
          end
          if (item.ride_status == ST_LEFT || item.ride_status == ST_RIGHT) begin
            nx.held_voice_side = SIDE_NONE;
            nx.mode            = MODE_TURN;
            nx.turn_side       = (item.ride_status == ST_LEFT) ? SIDE_LEFT : SIDE_RIGHT;
            nx.tick_count      = 10'd0;
            nx.blink_index     = 4'd0;
            nx.shown_pat       = (nx.turn_side == SIDE_LEFT) ? PAT_LEFT : PAT_RIGHT;
            nx.shown_phase     = nx.frame_step;
            nx.frame_step      = nx.frame_step + 8'd1;
          end else begin
            nx.phase = PH_TOP;
            if (nx.held_voice_side == SIDE_LEFT || nx.held_voice_side == SIDE_RIGHT) begin
              nx.shown_pat   = (nx.held_voice_side == SIDE_LEFT) ? PAT_LEFT : PAT_RIGHT;
              nx.shown_phase = nx.frame_step;
              nx.frame_step  = nx.frame_step + 8'd1;
            end else begin
              nx.shown_pat   = PAT_DARK;
              nx.shown_phase = '0;
            end
          end
          nx.wait_left = hold_ticks(cfg.frame_ticks);
          wrote        = 1'b1;
        end
      end
    end
  end

  assign st_nxt            = nx;
  assign res.pattern       = nx.shown_pat;
  assign res.rainbow_phase = nx.shown_phase;
  assign res.refresh       = wrote;

endmodule
`default_nettype wire

[design/turn_alarm_led_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// turn_alarm_led_sequencer
// LED strip sequencer for fall, proximity, turn and spoken-command events.
// ----------------------------------------------------------------------------
// Each request is one 10 ms tick and yields exactly one result. A request is
// taken every cycle unless a stalled result holds up the input register: it
// lands in the input register, and the whole tick update (state and strip
// write) is one pass of logic into the result register, from which its result
// is offered. Timing registers sit on the APB port at byte addresses 0, 4, 8,
// 12 and 16; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module turn_alarm_led_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  tals_in_if.sink                          in_ch,
  tals_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tals_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tals_pkg::DATA_W-1:0] pwdata,
  output logic      [tals_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import tals_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_ready;

  assign advance  = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !item_valid_r || advance;

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pattern       = res_r.pattern;
  assign out_ch.rainbow_phase = res_r.rainbow_phase;
  assign out_ch.refresh       = res_r.refresh;

  tals_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tals_step u_step (
    .cfg    (cfg),
    .cur_st (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= STATE_RST;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      item_r.ride_status    <= in_ch.ride_status;
      item_r.obstacle_near  <= in_ch.obstacle_near;
      item_r.spoken_command <= in_ch.spoken_command;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

[design/tals_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tals_port_checks
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module tals_port_checks (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [tals_pkg::PAT_W-1:0]   pattern,
  input wire logic [tals_pkg::PHASE_W-1:0] rainbow_phase,
  input wire logic                         refresh
);
  import tals_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pattern) &&
                                $stable(rainbow_phase) && $stable(refresh))
    else $error("stalled result changed");

  // dark and red carry no rainbow step
  a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pattern == PAT_DARK || pattern == PAT_RED) |-> rainbow_phase == '0)
    else $error("rainbow step on a non-rainbow pattern");

  // never refuse a request while the result side is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty result stage");

  // a taken request with a free result side gives a result via the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after request");

endmodule

bind turn_alarm_led_sequencer tals_port_checks u_tals_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pattern       (out_ch.pattern),
  .rainbow_phase (out_ch.rainbow_phase),
  .refresh       (out_ch.refresh)
);
`default_nettype wire

[tb/tals_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tals_checker
// Watches the request, result and APB ports of the LED sequencer, keeps its
// own model of the tick-by-tick strip update, and compares each result
// against the oldest predicted frame.
// ----------------------------------------------------------------------------
module tals_checker
  import tals_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  tals_in_if                     in_mon,
  tals_out_if                    out_mon,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output int                     requests_in_flight,
  output int                     mismatches
);

  cfg_t               regs;
  logic [1:0]         seq_mode;
  logic [9:0]         elapsed_ticks;
  logic [3:0]         blink_no;
  logic [1:0]         turn_strip;
  logic               alarm_held;
  logic [1:0]         voice_strip;
  logic [7:0]         frame_no;
  logic [CMD_W-1:0]   cmd_waiting;
  logic [7:0]         hold_left;
  logic [1:0]         blink_phase;
  logic [PAT_W-1:0]   lit_pat;
  logic [PHASE_W-1:0] lit_phase;
  logic               lit_fresh;
  logic [STATUS_W-1:0] now_status;
  logic               now_near;

  result_t led_frames_due[$];
  int      fail_total;

  function automatic int at_least_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void reset_predictor();
    regs.blink_count     = BLINK_COUNT_RST;
    regs.blink_on_ticks  = BLINK_ON_TICKS_RST;
    regs.blink_off_ticks = BLINK_OFF_TICKS_RST;
    regs.frame_ticks     = FRAME_TICKS_RST;
    regs.turn_ticks      = TURN_TICKS_RST;
    seq_mode      = MODE_IDLE;
    elapsed_ticks = '0;
    blink_no      = '0;
    turn_strip    = SIDE_NONE;
    alarm_held    = 1'b0;
    voice_strip   = SIDE_NONE;
    frame_no      = '0;
    cmd_waiting   = CMD_NONE;
    hold_left     = '0;
    blink_phase   = PH_TOP;
    lit_pat       = PAT_DARK;
    lit_phase     = '0;
    lit_fresh     = 1'b0;
  endfunction

  function automatic void paint(input logic [PAT_W-1:0] pat, input logic [PHASE_W-1:0] ph,
                                input int ticks);
    lit_pat   = pat;
    lit_phase = ph;
    hold_left = 8'(at_least_one(ticks) - 1);
    lit_fresh = 1'b1;
  endfunction

  function automatic void paint_rainbow(input logic [1:0] strip, input int ticks);
    paint((strip == SIDE_LEFT) ? PAT_LEFT : PAT_RIGHT, frame_no, ticks);
    frame_no = frame_no + 8'd1;
  endfunction

  function automatic void light_red();
    blink_phase = PH_ON;
    paint(PAT_RED, '0, regs.blink_on_ticks);
  endfunction

  function automatic void top_decision();
    bit               again;
    logic [CMD_W-1:0] c;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      if (now_status == ST_FALL) begin
        seq_mode = MODE_FALL;
        blink_no = '0;
        light_red();
      end else if (cmd_waiting != CMD_NONE) begin
        c = cmd_waiting;
        cmd_waiting = CMD_NONE;
        if (c == CMD_LEFT_ON || c == CMD_RIGHT_ON) begin
          voice_strip = (c == CMD_LEFT_ON) ? SIDE_LEFT : SIDE_RIGHT;
          frame_no = frame_no + 8'd1;
        end else begin
          voice_strip = SIDE_NONE;
        end
        seq_mode = MODE_IDLE;
        blink_no = '0;
        again = 1'b1;
      end else if (seq_mode == MODE_FALL) begin
        blink_phase = PH_TOP;
        hold_left = '0;
      end else if (seq_mode == MODE_PROX) begin
        if (!now_near) begin
          seq_mode = MODE_IDLE;
          alarm_held = 1'b0;
          again = 1'b1;
        end else begin
          blink_no = '0;
          light_red();
        end
      end else begin
        seq_mode = MODE_IDLE;
        if (now_near && !alarm_held) begin
          alarm_held = 1'b1;
          seq_mode = MODE_PROX;
          blink_no = '0;
        end
        if (!now_near) alarm_held = 1'b0;
        if (now_status == ST_LEFT || now_status == ST_RIGHT) begin
          voice_strip = SIDE_NONE;
          seq_mode = MODE_TURN;
          turn_strip = (now_status == ST_LEFT) ? SIDE_LEFT : SIDE_RIGHT;
          elapsed_ticks = '0;
          blink_no = '0;
          paint_rainbow(turn_strip, regs.frame_ticks);
        end else begin
          blink_phase = PH_TOP;
          if (voice_strip == SIDE_LEFT || voice_strip == SIDE_RIGHT) begin
            paint_rainbow(voice_strip, regs.frame_ticks);
          end else begin
            paint(PAT_DARK, '0, regs.frame_ticks);
          end
        end
      end
    end
  endfunction

  function automatic void blink_advance();
    if (blink_phase == PH_ON) begin
      blink_phase = PH_OFF;
      paint(PAT_DARK, '0, regs.blink_off_ticks);
    end else begin
      if (blink_no < 4'd15) blink_no = blink_no + 4'd1;
      if (int'(blink_no) < at_least_one(regs.blink_count) &&
          (seq_mode == MODE_FALL || now_near)) begin
        light_red();
      end else begin
        top_decision();
      end
    end
  endfunction

  function automatic void tick_decision();
    int elapsed;
    if (seq_mode == MODE_TURN) begin
      elapsed = int'(elapsed_ticks) + at_least_one(regs.frame_ticks);
      if (elapsed < at_least_one(regs.turn_ticks) && cmd_waiting == CMD_NONE) begin
        elapsed_ticks = 10'(elapsed);
        paint_rainbow(turn_strip, regs.frame_ticks);
      end else begin
        seq_mode = MODE_IDLE;
        elapsed_ticks = '0;
        top_decision();
      end
    end else if ((seq_mode == MODE_PROX || seq_mode == MODE_FALL) && blink_phase != PH_TOP) begin
      blink_advance();
    end else begin
      top_decision();
    end
  endfunction

  function automatic result_t next_led_frame(input item_t req);
    result_t r;
    now_status = req.ride_status;
    now_near   = req.obstacle_near;
    if (req.spoken_command >= CMD_LEFT_ON && req.spoken_command <= CMD_RIGHT_OFF)
      cmd_waiting = req.spoken_command;
    lit_fresh = 1'b0;
    if (hold_left > 0) hold_left = hold_left - 8'd1;
    else tick_decision();
    r.pattern       = lit_pat;
    r.rainbow_phase = lit_phase;
    r.refresh       = lit_fresh;
    return r;
  endfunction

  initial begin
    fail_total = 0;
    reset_predictor();
  end

  always @(posedge clk) begin
    item_t   req;
    result_t want;
    result_t got;
    if (!rst_n) begin
      reset_predictor();
      led_frames_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_BLINK_COUNT:     regs.blink_count     = pwdata[3:0];
          REG_BLINK_ON_TICKS:  regs.blink_on_ticks  = pwdata[7:0];
          REG_BLINK_OFF_TICKS: regs.blink_off_ticks = pwdata[7:0];
          REG_FRAME_TICKS:     regs.frame_ticks     = pwdata[7:0];
          REG_TURN_TICKS:      regs.turn_ticks      = pwdata[9:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        req.ride_status    = in_mon.ride_status;
        req.obstacle_near  = in_mon.obstacle_near;
        req.spoken_command = in_mon.spoken_command;
        led_frames_due.push_back(next_led_frame(req));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.pattern       = out_mon.pattern;
        got.rainbow_phase = out_mon.rainbow_phase;
        got.refresh       = out_mon.refresh;
        if (led_frames_due.size() == 0) begin
          $error("result with no request outstanding: pattern %0d phase %0d refresh %0d",
                 got.pattern, got.rainbow_phase, got.refresh);
          fail_total++;
        end else begin
          want = led_frames_due.pop_front();
          if (got.pattern !== want.pattern) begin
            $error("pattern: expected %0d, got %0d", want.pattern, got.pattern);
            fail_total++;
          end
          if (got.rainbow_phase !== want.rainbow_phase) begin
            $error("rainbow_phase: expected %0d, got %0d", want.rainbow_phase, got.rainbow_phase);
            fail_total++;
          end
          if (got.refresh !== want.refresh) begin
            $error("refresh: expected %0d, got %0d", want.refresh, got.refresh);
            fail_total++;
          end
        end
      end
    end
    requests_in_flight <= led_frames_due.size();
    mismatches         <= fail_total;
  end

endmodule

[tb/turn_alarm_led_sequencer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turn_alarm_led_sequencer_test
// Drives tick requests and APB register writes into the LED sequencer under
// random idling and back-pressure: a directed pass over every status, each
// valid command and two invalid ones, then shaped random runs at minimum,
// zero, maximum, reset and random timing settings; tals_checker checks results.
// ----------------------------------------------------------------------------
module turn_alarm_led_sequencer_test;
  import tals_pkg::*;

  localparam logic [STATUS_W-1:0] ST_NORMAL    = 2'd0;
  localparam logic [CMD_W-1:0]    CMD_LEFT_OFF = 3'd2;
  localparam logic [CMD_W-1:0]    CMD_BAD_LO   = 3'd5;
  localparam logic [CMD_W-1:0]    CMD_BAD_HI   = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int  in_flight;
  int  error_total;
  bit  in_idle_on;
  bit  out_idle_on;

  logic [STATUS_W-1:0] run_status;
  logic                run_near;
  int                  status_run_left;
  int                  near_run_left;

  tals_in_if  in_ch ();
  tals_out_if out_ch ();

  turn_alarm_led_sequencer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tals_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .requests_in_flight (in_flight),
    .mismatches         (error_total)
  );

  always #1 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_tick(input logic [STATUS_W-1:0] st, input logic nr,
                           input logic [CMD_W-1:0] cmd);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.ride_status    <= st;
    in_ch.obstacle_near  <= nr;
    in_ch.spoken_command <= cmd;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(input logic [DATA_W-1:0] bc, input logic [DATA_W-1:0] on_t,
                            input logic [DATA_W-1:0] off_t, input logic [DATA_W-1:0] fr_t,
                            input logic [DATA_W-1:0] turn_t);
    drain();
    cfg_write(REG_BLINK_COUNT, bc);
    cfg_write(REG_BLINK_ON_TICKS, on_t);
    cfg_write(REG_BLINK_OFF_TICKS, off_t);
    cfg_write(REG_FRAME_TICKS, fr_t);
    cfg_write(REG_TURN_TICKS, turn_t);
  endtask

  // hold status and alarm levels for runs of ticks; mix in sparse commands and noise
  task automatic run_random(input int n);
    int               k;
    int               roll;
    logic [CMD_W-1:0] cmd;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (status_run_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      run_status = ST_NORMAL;
        else if (roll < 68) run_status = ST_LEFT;
        else if (roll < 90) run_status = ST_RIGHT;
        else                run_status = ST_FALL;
        status_run_left = (run_status == ST_FALL) ? $urandom_range(1, 3) : $urandom_range(1, 25);
      end
      status_run_left--;
      if (near_run_left == 0) begin
        run_near = ($urandom_range(0, 2) == 0);
        near_run_left = $urandom_range(1, 30);
      end
      near_run_left--;
      roll = $urandom_range(0, 99);
      if (roll < 8)       cmd = CMD_W'($urandom_range(CMD_LEFT_ON, CMD_RIGHT_OFF));
      else if (roll < 11) cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      else                cmd = CMD_NONE;
      if ($urandom_range(0, 9) == 0)
        send_tick(STATUS_W'($urandom()), 1'($urandom()), CMD_W'($urandom()));
      else
        send_tick(run_status, run_near, cmd);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_idle_on && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin
    #2000000;
    $display("** turn_alarm_led_sequencer: FAILED **");
    $finish;
  end

  initial begin
    int k;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid          = 1'b0;
    in_ch.ride_status    = ST_NORMAL;
    in_ch.obstacle_near  = 1'b0;
    in_ch.spoken_command = CMD_NONE;
    in_idle_on      = 1'b1;
    out_idle_on     = 1'b1;
    run_status      = ST_NORMAL;
    run_near        = 1'b0;
    status_run_left = 0;
    near_run_left   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_timing(2, 1, 2, 2, 6);
    send_tick(ST_NORMAL, 1'b0, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_LEFT_ON);
    send_tick(ST_NORMAL, 1'b0, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_LEFT_OFF);
    send_tick(ST_NORMAL, 1'b0, CMD_RIGHT_ON);
    send_tick(ST_NORMAL, 1'b0, CMD_RIGHT_OFF);
    send_tick(ST_NORMAL, 1'b0, CMD_BAD_LO);
    send_tick(ST_LEFT, 1'b0, CMD_NONE);
    send_tick(ST_LEFT, 1'b0, CMD_NONE);
    send_tick(ST_LEFT, 1'b0, CMD_RIGHT_ON);
    send_tick(ST_RIGHT, 1'b1, CMD_NONE);
    send_tick(ST_RIGHT, 1'b1, CMD_BAD_HI);
    send_tick(ST_NORMAL, 1'b1, CMD_NONE);
    send_tick(ST_NORMAL, 1'b1, CMD_NONE);
    send_tick(ST_NORMAL, 1'b1, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_NONE);
    send_tick(ST_FALL, 1'b0, CMD_NONE);
    send_tick(ST_FALL, 1'b1, CMD_NONE);
    send_tick(ST_NORMAL, 1'b1, CMD_NONE);
    send_tick(ST_RIGHT, 1'b0, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_LEFT_ON);
    send_tick(ST_NORMAL, 1'b1, CMD_NONE);
    send_tick(ST_NORMAL, 1'b0, CMD_NONE);

    set_timing(1, 1, 1, 1, 1);
    run_random(100);
    set_timing(0, 0, 0, 0, 0);
    run_random(60);
    set_timing(15, 255, 255, 255, 1023);
    run_random(60);
    set_timing(BLINK_COUNT_RST, BLINK_ON_TICKS_RST, BLINK_OFF_TICKS_RST, FRAME_TICKS_RST,
               TURN_TICKS_RST);
    run_random(80);
    for (k = 0; k < 4; k++) begin
      set_timing($urandom_range(1, 15), $urandom_range(1, 4), $urandom_range(1, 4),
                 $urandom_range(1, 6), $urandom_range(1, 60));
      run_random(75);
    end
    drain();

    if (error_total == 0) begin
      $display("** turn_alarm_led_sequencer: PASSED **");
    end else begin
      $display("** turn_alarm_led_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
